// ===== rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared constants, types and the microcode program of the scalar Kalman
// smoother core.
// ----------------------------------------------------------------------------
package sks_pkg;

    // Fixed-point format
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int Q_W      = 32;
    localparam int SAMPLE_W = 16;
    localparam int FILT_W   = 16;
    localparam int GAIN_W   = FRAC_BITS + 1;
    localparam int PROD_W   = 2 * Q_W;
    localparam int SUM_W    = Q_W + 1;
    localparam int DIVR_W   = Q_W + 2;
    localparam int CNT_W    = $clog2(FRAC_BITS + 1);

    localparam logic [GAIN_W-1:0] ONE_Q    = GAIN_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] SMP_MASK = (PROD_W'(1) << SAMPLE_BITS) - PROD_W'(1);

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd2;

    localparam logic [Q_W-1:0] MEAS_ERR_RST  = 32'd65536;
    localparam logic [Q_W-1:0] INIT_ERR_RST  = 32'd65536;
    localparam logic [Q_W-1:0] PROC_NOISE_RST = 32'd655;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_KLAT,
        OP_MUL_STEP,
        OP_MUL_T1,
        OP_MUL_T2,
        OP_ERR,
        OP_OUT
    } dp_op_t;

    // Hold conditions: the step repeats while its condition is true
    typedef enum logic [1:0] {
        COND_NONE,
        COND_WAIT_IN,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_ENTRY = 4'd0;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        pc_t    next_pc;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        dp_op_t op;
        logic   fire;
    } ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } stat_t;

    // Microcode program, one control word per step
    function automatic ucode_t prog_word(pc_t pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{op: OP_LOAD,     cond: COND_WAIT_IN,  next_pc: 4'd1};
            4'd1:    w = '{op: OP_DIFF,     cond: COND_NONE,     next_pc: 4'd2};
            4'd2:    w = '{op: OP_NOP,      cond: COND_DIV_BUSY, next_pc: 4'd3};
            4'd3:    w = '{op: OP_KLAT,     cond: COND_NONE,     next_pc: 4'd4};
            4'd4:    w = '{op: OP_MUL_STEP, cond: COND_NONE,     next_pc: 4'd5};
            4'd5:    w = '{op: OP_MUL_T1,   cond: COND_NONE,     next_pc: 4'd6};
            4'd6:    w = '{op: OP_MUL_T2,   cond: COND_NONE,     next_pc: 4'd7};
            4'd7:    w = '{op: OP_ERR,      cond: COND_NONE,     next_pc: 4'd8};
            4'd8:    w = '{op: OP_OUT,      cond: COND_OUT_BUSY, next_pc: PC_ENTRY};
            default: w = '{op: OP_NOP,      cond: COND_NONE,     next_pc: PC_ENTRY};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/sks_divider.sv =====
// ----------------------------------------------------------------------------
// sks_divider
// Restoring divider for the gain: quotient = (dividend << FRAC_BITS) / divisor,
// valid when dividend <= divisor. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module sks_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sks_pkg::Q_W-1:0]     dividend,
    input  logic [sks_pkg::SUM_W-1:0]   divisor,
    output logic                        busy,
    output logic [sks_pkg::GAIN_W-1:0]  quotient
);
    import sks_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [GAIN_W-1:0] quo_reg;

    logic [DIVR_W-1:0] dsr;
    logic [DIVR_W-1:0] dvd;
    logic [DIVR_W-1:0] trial;

    assign dsr   = DIVR_W'(divisor);
    assign dvd   = DIVR_W'(dividend);
    assign trial = {rem_reg[DIVR_W-2:0], 1'b0};

    // Iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(FRAC_BITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Remainder and quotient; the integer bit is settled at start
    always_ff @(posedge aclk) begin
        if (start) begin
            if (dvd >= dsr) begin
                rem_reg <= dvd - dsr;
                quo_reg <= GAIN_W'(1);
            end else begin
                rem_reg <= dvd;
                quo_reg <= '0;
            end
        end else if (cnt_reg != '0) begin
            if (trial >= dsr) begin
                rem_reg <= trial - dsr;
                quo_reg <= {quo_reg[GAIN_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[GAIN_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

`ifndef NO_ASSERTIONS
    // Partial remainder stays below a nonzero divisor while iterating
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0 && dsr != '0) |-> (rem_reg < dsr))
        else $error("divider remainder out of range");

    // Counter never loaded past the iteration count
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FRAC_BITS))
        else $error("divider counter out of range");
`endif

endmodule

// ===== rtl/sks_datapath.sv =====
// ----------------------------------------------------------------------------
// sks_datapath
// Registers, shared 32x32 multiplier, gain divider, configuration registers
// and the output register, driven one operation per step by the sequencer.
// ----------------------------------------------------------------------------
module sks_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sks_pkg::ctl_t                      ctl,
    output sks_pkg::stat_t                     stat,
    input  logic                               cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sks_pkg::Q_W-1:0]            cfg_wdata,
    input  logic [sks_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sks_pkg::FILT_W-1:0]         m_filtered_value,
    output logic [sks_pkg::Q_W-1:0]            m_estimate_fixed,
    output logic [sks_pkg::GAIN_W-1:0]         m_gain,
    output logic [sks_pkg::Q_W-1:0]            m_estimate_error_out
);
    import sks_pkg::*;

    // Configuration and filter state
    logic [Q_W-1:0] meas_err_reg;
    logic [Q_W-1:0] proc_noise_reg;
    logic [Q_W-1:0] last_reg;
    logic [Q_W-1:0] err_est_reg;

    // Per-item working registers
    logic [Q_W-1:0]    target_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              up_reg;
    logic [Q_W-1:0]    mag_reg;
    logic [GAIN_W-1:0] k_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [Q_W-1:0]    step_reg;
    logic [Q_W-1:0]    t1_reg;
    logic [Q_W-1:0]    est_reg;
    logic [Q_W-1:0]    err_reg;

    // Output register
    logic              m_valid_reg;
    logic [Q_W-1:0]    m_est_reg;
    logic [GAIN_W-1:0] m_gain_reg;
    logic [Q_W-1:0]    m_err_reg;

    logic              div_start;
    logic              div_busy;
    logic [GAIN_W-1:0] div_quo;

    logic [PROD_W-1:0] target_wide;
    logic [Q_W-1:0]    target_sat;
    logic [Q_W-1:0]    mul_a;
    logic [Q_W-1:0]    mul_b;
    logic [PROD_W-1:0] prod_shr;
    logic [PROD_W-1:0] err_sum;
    logic [Q_W-1:0]    newest;
    logic              fire_out;

    // Sample scaled to Q format, saturated to 32 bits
    assign target_wide = (PROD_W'(s_sample) & SMP_MASK) << FRAC_BITS;
    assign target_sat  = (|target_wide[PROD_W-1:Q_W]) ? '1 : target_wide[Q_W-1:0];

    assign prod_shr = prod_reg >> FRAC_BITS;
    assign err_sum  = PROD_W'(t1_reg) + prod_shr;
    assign newest   = up_reg ? (last_reg + step_reg) : (last_reg - step_reg);

    assign div_start = ctl.fire && (ctl.op == OP_DIFF);
    assign fire_out  = ctl.fire && (ctl.op == OP_OUT);

    // Gain divider
    sks_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (err_est_reg),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Multiplier operand select
    always_comb begin
        case (ctl.op)
            OP_MUL_STEP: begin
                mul_a = mag_reg;
                mul_b = Q_W'(k_reg);
            end
            OP_MUL_T1: begin
                mul_a = err_est_reg;
                mul_b = Q_W'(ONE_Q - k_reg);
            end
            OP_MUL_T2: begin
                mul_a = step_reg;
                mul_b = proc_noise_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Working registers, one operation per step
    always_ff @(posedge aclk) begin
        if (ctl.fire) begin
            case (ctl.op)
                OP_LOAD: begin
                    target_reg <= target_sat;
                    sum_reg    <= SUM_W'(err_est_reg) + SUM_W'(meas_err_reg);
                end
                OP_DIFF: begin
                    up_reg  <= (target_reg >= last_reg);
                    mag_reg <= (target_reg >= last_reg) ? (target_reg - last_reg)
                                                        : (last_reg - target_reg);
                end
                OP_KLAT: begin
                    k_reg <= (sum_reg == '0) ? '0 : div_quo;
                end
                OP_MUL_STEP: begin
                    prod_reg <= mul_a * mul_b;
                end
                OP_MUL_T1: begin
                    step_reg <= prod_shr[Q_W-1:0];
                    prod_reg <= mul_a * mul_b;
                end
                OP_MUL_T2: begin
                    t1_reg   <= prod_shr[Q_W-1:0];
                    est_reg  <= newest;
                    prod_reg <= mul_a * mul_b;
                end
                OP_ERR: begin
                    err_reg <= (|err_sum[PROD_W-1:Q_W]) ? '1 : err_sum[Q_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration registers and filter state; an initial error write
    // goes straight into the error state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_err_reg   <= MEAS_ERR_RST;
            proc_noise_reg <= PROC_NOISE_RST;
            last_reg       <= '0;
            err_est_reg    <= INIT_ERR_RST;
        end else begin
            if (fire_out) begin
                last_reg    <= est_reg;
                err_est_reg <= err_reg;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MEAS_ERR: meas_err_reg <= cfg_wdata;
                    REG_INIT_ERR: err_est_reg <= cfg_wdata;
                    REG_PROC_NOISE: proc_noise_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge aclk) begin
        if (fire_out) begin
            m_est_reg  <= est_reg;
            m_gain_reg <= k_reg;
            m_err_reg  <= err_reg;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid              = m_valid_reg;
    assign m_filtered_value     = FILT_W'(m_est_reg >> FRAC_BITS);
    assign m_estimate_fixed     = m_est_reg;
    assign m_gain               = m_gain_reg;
    assign m_estimate_error_out = m_err_reg;

`ifndef NO_ASSERTIONS
    // Gain used in the multiplies never exceeds one
    a_gain_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.fire && ctl.op == OP_MUL_STEP) |-> (k_reg <= ONE_Q))
        else $error("gain above one");

    // New estimate lies between the last estimate and the target
    a_est_between: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_out |-> (up_reg ? (est_reg >= last_reg && est_reg <= target_reg)
                             : (est_reg <= last_reg && est_reg >= target_reg)))
        else $error("estimate outside last/target interval");

    // Divisor holds while the divider runs
    a_sum_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |=> $stable(sum_reg))
        else $error("divisor changed during division");

    // Output register is only loaded when free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before delivery");
`endif

endmodule

// ===== rtl/sks_sequencer.sv =====
// ----------------------------------------------------------------------------
// sks_sequencer
// Step counter over the microcode program; each step repeats while its hold
// condition is true, then jumps to the word's next step.
// ----------------------------------------------------------------------------
module sks_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sks_pkg::stat_t stat,
    output sks_pkg::ctl_t  ctl
);
    import sks_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t word;
    logic   hold;

    assign word = prog_word(pc_reg);

    // Hold condition decode
    always_comb begin
        case (word.cond)
            COND_WAIT_IN:  hold = !s_valid;
            COND_DIV_BUSY: hold = stat.div_busy;
            COND_OUT_BUSY: hold = stat.out_busy;
            default:       hold = 1'b0;
        endcase
    end

    assign pc_next = hold ? pc_reg : word.next_pc;

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_ENTRY;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctl.op   = word.op;
    assign ctl.fire = !hold;
    assign s_ready  = (pc_reg == PC_ENTRY);

endmodule

// ===== rtl/scalar_kalman_smoother_core.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_core
// Scalar Kalman smoother for unsigned sensor samples, Q16.16 state.
//
// Usage:
//   Input channel s_valid/s_ready/s_sample carries one raw sample per item.
//   Result channel m_valid/m_ready carries filtered value, Q16.16 estimate,
//   gain (Q1.16) and updated estimate error for each sample.
//   Configuration: cfg_we/cfg_addr/cfg_wdata, index 0 measurement error,
//   1 initial estimate error (also reloads the error state), 2 process noise.
//   Write configuration only while no item is in flight.
// Flow:
//   From acceptance to m_valid an item runs the 8 microcode steps after
//   the entry step, one of which waits on the bit-serial gain divider.
//   One item is in flight at a time; s_ready is high only at the
//   program entry step, so a new sample waits until the last has left it.
//   The result sits in an output register, so the next item is accepted and
//   processed while it waits; the last step holds if m_ready stays low.
// Reset: synchronous, active low; configuration registers return to their defaults, the
//   estimate clears to zero and the error loads the initial error.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [sks_pkg::Q_W-1:0]           cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sks_pkg::SAMPLE_W-1:0]      s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sks_pkg::FILT_W-1:0]        m_filtered_value,
    output logic [sks_pkg::Q_W-1:0]           m_estimate_fixed,
    output logic [sks_pkg::GAIN_W-1:0]        m_gain,
    output logic [sks_pkg::Q_W-1:0]           m_estimate_error_out
);
    import sks_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // Microcode control
    sks_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Arithmetic, state and output register
    sks_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctl                  (ctl),
        .stat                 (stat),
        .cfg_we               (cfg_we),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_sample             (s_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_filtered_value     (m_filtered_value),
        .m_estimate_fixed     (m_estimate_fixed),
        .m_gain               (m_gain),
        .m_estimate_error_out (m_estimate_error_out)
    );

endmodule
